FILE: rtl/rgbe_pkg.sv
// Shared types, constants and helper functions for the RGBE codec.
package rgbe_pkg;

   localparam logic [31:0] BLACK_LIMIT_BITS = 32'h0A4F_B11F;
   localparam logic [7:0]  BIAS_CODE        = 8'd250;
   localparam logic [7:0]  DECODE_MIN_EXP   = 8'd109;
   localparam logic [7:0]  WRAP_EXP         = 8'd131;
   localparam logic        MODE_ENCODE      = 1'b0;
   localparam logic        MODE_DECODE      = 1'b1;

   // Result payload carried between the datapath and the output register.
   typedef struct packed {
      logic [7:0]  red_byte;
      logic [7:0]  green_byte;
      logic [7:0]  blue_byte;
      logic [7:0]  exp_byte;
      logic [31:0] red_flt;
      logic [31:0] green_flt;
      logic [31:0] blue_flt;
      logic        range_flag;
   } result_type;

   // Floor of one channel scaled to the shared exponent.
   function automatic logic [7:0] chan_byte(input logic [31:0] b, input logic [7:0] emax);
      logic [7:0]  ec;
      logic [23:0] sig;
      logic [8:0]  sh;
      logic [23:0] shifted;
      ec  = b[30:23];
      sig = {1'b0, b[22:0]};
      if (ec == 8'd0) begin
         ec = 8'd1;
      end else begin
         sig[23] = 1'b1;
      end
      sh      = 9'd16 + {1'b0, emax} - {1'b0, ec};
      shifted = sig >> sh[4:0];
      if (b[31] || (ec > emax) || (sh > 9'd31)) begin
         chan_byte = 8'd0;
      end else begin
         chan_byte = shifted[7:0];
      end
   endfunction

   // Position of the leading one in a nonzero byte.
   function automatic logic [2:0] lead_one(input logic [7:0] v);
      logic [2:0] p;
      p = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (v[i]) begin
            p = 3'(i);
         end
      end
      lead_one = p;
   endfunction

   // IEEE single bits of byte * 2^(ex-258).
   function automatic logic [31:0] decode_chan(input logic [7:0] v, input logic [7:0] ex);
      logic [2:0]  p;
      logic signed [10:0] sum;
      logic [10:0] t;
      logic [7:0]  man;
      p   = lead_one(v);
      sum = $signed({3'b000, ex}) - 11'sd258 + $signed({8'd0, p}) + 11'sd127;
      t   = 11'({3'b000, ex}) - 11'd258 + 11'd149;
      man = v << (3'd7 - p);
      if ((v == 8'd0) || (ex < DECODE_MIN_EXP)) begin
         decode_chan = 32'd0;
      end else if (sum >= 11'sd1) begin
         decode_chan = {1'b0, sum[7:0], man[6:0], 16'd0};
      end else begin
         decode_chan = {24'd0, v} << t[4:0];
      end
   endfunction

endpackage

FILE: rtl/rgbe_datapath.sv
// Three-stage pipelined encode/decode datapath with stall-aware valid bits.
module rgbe_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic                     mode,
   input  logic [31:0]              red_float,
   input  logic [31:0]              green_float,
   input  logic [31:0]              blue_float,
   input  logic [7:0]               red_code,
   input  logic [7:0]               green_code,
   input  logic [7:0]               blue_code,
   input  logic [7:0]               exponent_code,
   input  logic                     advance,
   output logic                     out_valid,
   output rgbe_pkg::result_type     out_result
);
   import rgbe_pkg::*;

   // Stage 1 registers: captured item.
   logic        v1_ff;
   logic        mode1_ff;
   logic [31:0] r1_ff, g1_ff, b1_ff;
   logic [7:0]  rc1_ff, gc1_ff, bc1_ff, ex1_ff;
   // Stage 2 registers: maximum and classification.
   logic        v2_ff;
   logic        mode2_ff;
   logic [31:0] r2_ff, g2_ff, b2_ff;
   logic [7:0]  rc2_ff, gc2_ff, bc2_ff, ex2_ff;
   logic [31:0] max2_ff;
   logic        nf2_ff;
   // Stage 3 registers: result.
   logic        v3_ff;
   result_type  res3_ff;

   logic [31:0] mr, mg, mb, mrg, max_in;
   logic        nf_in;
   result_type  res_in;
   logic [7:0]  emax;

   // Stage 1 work: magnitudes, maximum and non-finite detection.
   always_comb begin
      mr     = r1_ff[31] ? 32'd0 : r1_ff;
      mg     = g1_ff[31] ? 32'd0 : g1_ff;
      mb     = b1_ff[31] ? 32'd0 : b1_ff;
      mrg    = (mg > mr) ? mg : mr;
      max_in = (mb > mrg) ? mb : mrg;
      nf_in  = (r1_ff[30:23] == 8'hFF) || (g1_ff[30:23] == 8'hFF)
            || (b1_ff[30:23] == 8'hFF);
   end

   // Stage 2 work: channel bytes or decoded floats.
   always_comb begin
      emax   = max2_ff[30:23];
      res_in = '0;
      if (mode2_ff == MODE_ENCODE) begin
         if (nf2_ff) begin
            res_in.range_flag = 1'b1;
         end else if (max2_ff >= BLACK_LIMIT_BITS) begin
            res_in.red_byte   = chan_byte(r2_ff, emax);
            res_in.green_byte = chan_byte(g2_ff, emax);
            res_in.blue_byte  = chan_byte(b2_ff, emax);
            res_in.exp_byte   = emax + BIAS_CODE - 8'd126;
            res_in.range_flag = emax > WRAP_EXP;
         end
      end else if (ex2_ff != 8'd0) begin
         res_in.red_flt   = decode_chan(rc2_ff, ex2_ff);
         res_in.green_flt = decode_chan(gc2_ff, ex2_ff);
         res_in.blue_flt  = decode_chan(bc2_ff, ex2_ff);
      end
   end

   // Valid bits move with the pipeline whenever it advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         mode1_ff <= mode;
         r1_ff    <= red_float;
         g1_ff    <= green_float;
         b1_ff    <= blue_float;
         rc1_ff   <= red_code;
         gc1_ff   <= green_code;
         bc1_ff   <= blue_code;
         ex1_ff   <= exponent_code;
         mode2_ff <= mode1_ff;
         r2_ff    <= r1_ff;
         g2_ff    <= g1_ff;
         b2_ff    <= b1_ff;
         rc2_ff   <= rc1_ff;
         gc2_ff   <= gc1_ff;
         bc2_ff   <= bc1_ff;
         ex2_ff   <= ex1_ff;
         max2_ff  <= max_in;
         nf2_ff   <= nf_in;
         res3_ff  <= res_in;
      end
   end

   assign out_valid  = v3_ff;
   assign out_result = res3_ff;

endmodule

FILE: rtl/rgbe_shared_exponent_codec.sv
// Top level of the RGBE shared-exponent pixel codec.
// An accepted item passes through the stage 1, stage 2 and stage 3 registers to the rsp_ ports.
// Throughput: one item per cycle while the output does not stall; the three-stage datapath sets the latency.
// A stall on the result side holds the whole pipeline; req_stall follows it
// only when the last stage holds an item that has not been taken.
// Reset (synchronous, active high) clears all valid bits; payloads are not reset.
module rgbe_shared_exponent_codec (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_red_float,
   input  logic [31:0] req_green_float,
   input  logic [31:0] req_blue_float,
   input  logic [7:0]  req_red_code,
   input  logic [7:0]  req_green_code,
   input  logic [7:0]  req_blue_code,
   input  logic [7:0]  req_exponent_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_byte_out,
   output logic [7:0]  rsp_green_byte_out,
   output logic [7:0]  rsp_blue_byte_out,
   output logic [7:0]  rsp_exponent_byte_out,
   output logic [31:0] rsp_red_float_out,
   output logic [31:0] rsp_green_float_out,
   output logic [31:0] rsp_blue_float_out,
   output logic        rsp_range_flag
);
   import rgbe_pkg::*;

   logic       advance;
   result_type res;

   // The pipeline moves unless a finished item waits at a stalled output.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   rgbe_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .mode          (req_mode),
      .red_float     (req_red_float),
      .green_float   (req_green_float),
      .blue_float    (req_blue_float),
      .red_code      (req_red_code),
      .green_code    (req_green_code),
      .blue_code     (req_blue_code),
      .exponent_code (req_exponent_code),
      .advance       (advance),
      .out_valid     (rsp_valid),
      .out_result    (res)
   );

   assign rsp_red_byte_out      = res.red_byte;
   assign rsp_green_byte_out    = res.green_byte;
   assign rsp_blue_byte_out     = res.blue_byte;
   assign rsp_exponent_byte_out = res.exp_byte;
   assign rsp_red_float_out     = res.red_flt;
   assign rsp_green_float_out   = res.green_flt;
   assign rsp_blue_float_out    = res.blue_flt;
   assign rsp_range_flag        = res.range_flag;

   // An encoded result never carries decoded floats alongside nonzero bytes.
   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_red_byte_out | rsp_exponent_byte_out) != 8'd0)
      |-> (rsp_red_float_out | rsp_green_float_out | rsp_blue_float_out) == 32'd0)
      else $error("encode and decode fields both nonzero");

   // Input is held off only while a result is stuck at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // A held result keeps its payload (red float and exponent byte are checked).
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_float_out)
      && $stable(rsp_exponent_byte_out))
      else $error("stalled result changed");

endmodule

FILE: sim/tb.sv
// Testbench for the RGBE shared-exponent codec: directed and random pixels.
`timescale 1ns / 1ps

module tb;
   import rgbe_pkg::*;

   // One pixel result as the block presents it.
   typedef struct {
      logic [7:0]  red_b, green_b, blue_b, exp_b;
      logic [31:0] red_f, green_f, blue_f;
      logic        flag;
   } pixel_type;

   // Scoreboard: predicts each accepted pixel and checks results in order.
   class pixel_scoreboard;
      pixel_type pending[$];
      int        errors;

      function new();
         errors = 0;
      endfunction

      // Floor of one channel scaled to the shared exponent.
      function automatic logic [7:0] scale_channel(logic [31:0] bits, int top_exp);
         int          ch_exp;
         int          shift;
         logic [31:0] sig;
         if (bits[31]) return 8'd0;
         ch_exp = bits[30:23];
         sig = {9'd0, bits[22:0]};
         if (ch_exp == 0) ch_exp = 1;
         else sig[23] = 1'b1;
         if (ch_exp > top_exp) return 8'd0;
         shift = 16 + top_exp - ch_exp;
         if (shift > 31) return 8'd0;
         return 8'(sig >> shift);
      endfunction

      // Single-precision bits of code * 2^(exp - 258).
      function automatic logic [31:0] expand_channel(logic [7:0] code, logic [7:0] ex);
         int k;
         int lead;
         logic [31:0] mant;
         if (code == 0 || ex < DECODE_MIN_EXP) return 32'd0;
         k = int'(ex) - 258;
         lead = 7;
         while (lead > 0 && !code[lead]) lead--;
         if (lead + k >= -126) begin
            mant = ({24'd0, code} << (23 - lead)) & 32'h007F_FFFF;
            return (32'(lead + k + 127) << 23) | mant;
         end
         return {24'd0, code} << (k + 149);
      endfunction

      function automatic logic [31:0] magnitude(logic [31:0] bits);
         return bits[31] ? 32'd0 : bits;
      endfunction

      // Notes one accepted input pixel and stores its expected result.
      function void note_pixel(logic mode, logic [31:0] rf, logic [31:0] gf, logic [31:0] bf,
                               logic [7:0] rc, logic [7:0] gc, logic [7:0] bc, logic [7:0] ec);
         pixel_type   p;
         logic [31:0] top;
         int          top_exp;
         p = '{default: '0};
         if (mode == MODE_ENCODE) begin
            if (&rf[30:23] || &gf[30:23] || &bf[30:23]) begin
               p.flag = 1'b1;
            end else begin
               top = magnitude(rf);
               if (magnitude(gf) > top) top = magnitude(gf);
               if (magnitude(bf) > top) top = magnitude(bf);
               if (top >= BLACK_LIMIT_BITS) begin
                  top_exp = top[30:23];
                  p.red_b   = scale_channel(rf, top_exp);
                  p.green_b = scale_channel(gf, top_exp);
                  p.blue_b  = scale_channel(bf, top_exp);
                  p.exp_b   = 8'(top_exp + 250 - 126);
                  p.flag    = top_exp > 131;
               end
            end
         end else if (ec != 0) begin
            p.red_f   = expand_channel(rc, ec);
            p.green_f = expand_channel(gc, ec);
            p.blue_f  = expand_channel(bc, ec);
         end
         pending.push_back(p);
      endfunction

      // Compares one result with the oldest expectation.
      function void check_pixel(pixel_type got);
         pixel_type want;
         if (pending.size() == 0) begin
            $error("result with no expected item waiting");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.red_b !== want.red_b) begin
            $error("red_byte_out: expected %h, got %h", want.red_b, got.red_b); errors++;
         end
         if (got.green_b !== want.green_b) begin
            $error("green_byte_out: expected %h, got %h", want.green_b, got.green_b); errors++;
         end
         if (got.blue_b !== want.blue_b) begin
            $error("blue_byte_out: expected %h, got %h", want.blue_b, got.blue_b); errors++;
         end
         if (got.exp_b !== want.exp_b) begin
            $error("exponent_byte_out: expected %h, got %h", want.exp_b, got.exp_b); errors++;
         end
         if (got.red_f !== want.red_f) begin
            $error("red_float_out: expected %h, got %h", want.red_f, got.red_f); errors++;
         end
         if (got.green_f !== want.green_f) begin
            $error("green_float_out: expected %h, got %h", want.green_f, got.green_f);
            errors++;
         end
         if (got.blue_f !== want.blue_f) begin
            $error("blue_float_out: expected %h, got %h", want.blue_f, got.blue_f); errors++;
         end
         if (got.flag !== want.flag) begin
            $error("range_flag: expected %b, got %b", want.flag, got.flag); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [31:0] req_red_float = '0, req_green_float = '0, req_blue_float = '0;
   logic [7:0]  req_red_code = '0, req_green_code = '0, req_blue_code = '0;
   logic [7:0]  req_exponent_code = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [7:0]  rsp_red_byte_out, rsp_green_byte_out, rsp_blue_byte_out, rsp_exponent_byte_out;
   logic [31:0] rsp_red_float_out, rsp_green_float_out, rsp_blue_float_out;
   logic        rsp_range_flag;

   pixel_scoreboard board = new();
   bit   stimulus_done = 0;
   int   idle_cycles = 0;

   localparam int WATCHDOG_LIMIT = 2000;

   rgbe_shared_exponent_codec DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Random gap length: mostly short, now and then long.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Random single-precision pattern biased toward interesting regions.
   function automatic logic [31:0] pick_float(int shared_exp);
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(0, 9))
         0: v[30:23] = 8'hFF;
         1: v[30:23] = 8'h00;
         2: v[30:23] = 8'($urandom_range(15, 25));
         3, 4: v[30:23] = 8'($urandom_range(115, 140));
         5, 6, 7: v[30:23] = 8'(shared_exp - $urandom_range(0, 12));
         default: ;
      endcase
      if ($urandom_range(0, 3) != 0) v[31] = 1'b0;
      return v;
   endfunction

   // Offers one pixel and waits until the block takes it.
   task automatic send_pixel(logic mode, logic [31:0] rf, logic [31:0] gf, logic [31:0] bf,
                             logic [7:0] rc, logic [7:0] gc, logic [7:0] bc, logic [7:0] ec);
      int gap;
      gap = gap_length();
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_red_float <= rf;
      req_green_float <= gf;
      req_blue_float <= bf;
      req_red_code <= rc;
      req_green_code <= gc;
      req_blue_code <= bc;
      req_exponent_code <= ec;
      do @(posedge clock); while (req_stall);
      board.note_pixel(mode, rf, gf, bf, rc, gc, bc, ec);
   endtask

   task automatic send_encode(logic [31:0] rf, logic [31:0] gf, logic [31:0] bf);
      send_pixel(MODE_ENCODE, rf, gf, bf, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                 8'($urandom()));
   endtask

   task automatic send_decode(logic [7:0] rc, logic [7:0] gc, logic [7:0] bc, logic [7:0] ec);
      send_pixel(MODE_DECODE, $urandom(), $urandom(), $urandom(), rc, gc, bc, ec);
   endtask

   // Stimulus: directed corners, then random pixels.
   initial begin
      int se;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Black pixels, limit threshold and just below it.
      send_encode(32'h0, 32'h0, 32'h0);
      send_encode(32'h0A4F_B11E, 32'h0, 32'h8000_0000);
      send_encode(32'h0A4F_B11F, 32'h0, 32'h0);
      // Ordinary value and negative channels.
      send_encode(32'h3F80_0000, 32'hBF80_0000, 32'h3F00_0000);
      send_encode(32'h3F7F_FFFF, 32'h0000_0001, 32'h3C00_0000);
      // Exponent wrap edge: e = 5 and e = 6, and the largest finite value.
      send_encode(32'h41FF_FFFF, 32'h0, 32'h0);
      send_encode(32'h4200_0000, 32'h4100_0000, 32'h0);
      send_encode(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF);
      // Infinity of either sign, and a NaN.
      send_encode(32'h7F80_0000, 32'h0, 32'h0);
      send_encode(32'h0, 32'hFF80_0000, 32'h0);
      send_encode(32'h0, 32'h0, 32'hFFFF_FFFF);
      // Decode: black, tiny exponent, threshold, subnormal and extremes.
      send_decode(8'hFF, 8'hFF, 8'hFF, 8'd0);
      send_decode(8'hFF, 8'h01, 8'h80, 8'd1);
      send_decode(8'hFF, 8'h01, 8'h80, 8'd108);
      send_decode(8'hFF, 8'h01, 8'h80, 8'd109);
      send_decode(8'h00, 8'h7F, 8'h10, 8'd131);
      send_decode(8'h80, 8'h01, 8'hAA, 8'd250);
      send_decode(8'hFF, 8'hFF, 8'hFF, 8'd255);
      // Random pixels; a long receiver hold-off runs alongside.
      for (int n = 0; n < 940; n++) begin
         if ($urandom_range(0, 1) == 0) begin
            se = $urandom_range(1, 254);
            send_encode(pick_float(se), pick_float(se), pick_float(se));
         end else begin
            send_decode(8'($urandom()), 8'($urandom()), 8'($urandom()),
                        ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 110))
                                                    : 8'($urandom()));
         end
      end
      req_valid <= 1'b0;
      stimulus_done = 1;
   end

   // Receiver: random stalls, one long hold-off early in the random part.
   initial begin
      int gap;
      @(negedge reset);
      rsp_stall <= 1'b0;
      repeat (60) @(posedge clock);
      rsp_stall <= 1'b1;
      repeat (80) @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : gap_length();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Check every result taken by the receiver; count idle cycles.
   always @(posedge clock) begin
      pixel_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.red_b = rsp_red_byte_out;
            got.green_b = rsp_green_byte_out;
            got.blue_b = rsp_blue_byte_out;
            got.exp_b = rsp_exponent_byte_out;
            got.red_f = rsp_red_float_out;
            got.green_f = rsp_green_float_out;
            got.blue_f = rsp_blue_float_out;
            got.flag = rsp_range_flag;
            board.check_pixel(got);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // End of run and watchdog.
   initial begin
      @(negedge reset);
      while (!(stimulus_done && board.pending.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
      end else begin
         repeat (10) @(posedge clock);
         if (board.errors == 0) begin
            $display("tb passed");
         end else begin
            $display("tb failed");
         end
      end
      $finish;
   end
endmodule
